>>> sv/sb3_pkg.sv
// sb3_pkg: shared constants, types and helpers of the sobel 3x3 gradient block
// no dependencies; used by every other file of the block except sb3_line_ram
`default_nettype none

package sb3_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int HEIGHT_LIMIT = 2048;
   localparam int MIN_SIZE     = 5;

   localparam int PIX_W  = 8;
   localparam int GRAD_W = 11;
   localparam int SIZE_W = 12;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
   localparam int CMP_W  = SIZE_W + 1;
   localparam int SUM_W  = GRAD_W;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RESET  = 12'd512;
   localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RESET = 12'd512;

   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } column_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             emit;
      logic             interior;
      logic             frame_last;
      logic [PIX_W-1:0] pixel;
   } stage_type;

   // clamp a size register to [MIN_SIZE, hi]
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v, input int hi);
      logic [SIZE_W-1:0] r;
      if (32'(v) < MIN_SIZE) begin
         r = SIZE_W'(MIN_SIZE);
      end else if (32'(v) > hi) begin
         r = SIZE_W'(hi);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/sb3_req_if.sv
// sb3_req_if: pixel input channel, valid/ready with one grey pixel per item
// depends on sb3_pkg
`default_nettype none

interface sb3_req_if;
   logic                       valid;
   logic                       ready;
   logic [sb3_pkg::PIX_W-1:0]  pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

>>> sv/sb3_rsp_if.sv
// sb3_rsp_if: gradient result channel, valid/ready with grad_x, grad_y, frame_last
// depends on sb3_pkg
`default_nettype none

interface sb3_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [sb3_pkg::GRAD_W-1:0]  grad_x;
   logic signed [sb3_pkg::GRAD_W-1:0]  grad_y;
   logic                               frame_last;

   modport source (output valid, output grad_x, output grad_y, output frame_last, input ready);
   modport sink   (input valid, input grad_x, input grad_y, input frame_last, output ready);
endinterface

`default_nettype wire

>>> sv/sobel_3x3_gradient.sv
// sobel_3x3_gradient: streaming sobel gradient over raster-order grey pixels
// throughput: one pixel per cycle unless rsp_chan stalls, set by the single line memory
// read and write per cycle; accepted pixels pass the stage one and output registers
// reset: synchronous active high; clears counters, window and pipeline valids, sizes to 512
// line memory content is not cleared; entries are written before any interior read
// depends on sb3_pkg, sb3_req_if, sb3_rsp_if, sb3_line_ram, sb3_window
`default_nettype none

module sobel_3x3_gradient (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   sb3_req_if.sink                                    req_chan,
   sb3_rsp_if.source                                  rsp_chan,
   input  wire logic                                  csr_we,
   input  wire logic [sb3_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [sb3_pkg::SIZE_W-1:0]            csr_wdata
);

   logic [sb3_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [sb3_pkg::SIZE_W-1:0] height_ff, height_in;
   logic [sb3_pkg::SIZE_W-1:0] width_eff, height_eff;

   logic [sb3_pkg::COL_W-1:0] col_ff, col_in;
   logic [sb3_pkg::ROW_W-1:0] row_ff, row_in;

   logic                s1_valid_ff, s1_valid_in;
   sb3_pkg::stage_type  s1_ff, s1_in;

   logic                              out_valid_ff, out_valid_in;
   logic signed [sb3_pkg::GRAD_W-1:0] grad_x_ff, grad_x_in;
   logic signed [sb3_pkg::GRAD_W-1:0] grad_y_ff, grad_y_in;
   logic                              frame_last_ff, frame_last_in;

   logic advance, accept, row_end, frame_end, retire;
   logic [2*sb3_pkg::PIX_W-1:0] rd_data;
   sb3_pkg::column_type         column;
   logic signed [sb3_pkg::GRAD_W-1:0] win_gx, win_gy;

   // configuration
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            sb3_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            sb3_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sb3_pkg::IMAGE_WIDTH_RESET;
         height_ff <= sb3_pkg::IMAGE_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign width_eff  = sb3_pkg::clamp_size(width_ff, sb3_pkg::MAX_WIDTH);
   assign height_eff = sb3_pkg::clamp_size(height_ff, sb3_pkg::HEIGHT_LIMIT);

   // handshake
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;
   assign retire         = advance && s1_valid_ff;

   // position counters
   assign row_end   = (sb3_pkg::CMP_W'(col_ff) + 1'b1) >= {1'b0, width_eff};
   assign frame_end = row_end && ((sb3_pkg::CMP_W'(row_ff) + 1'b1) >= {1'b0, height_eff});

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // stage one: item waits for line memory read data
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (advance) begin
         s1_valid_in = accept;
      end
      if (accept) begin
         s1_in.col        = col_ff;
         s1_in.emit       = (col_ff != '0) && (row_ff != '0);
         s1_in.interior   = (col_ff > sb3_pkg::COL_W'(1)) && (row_ff > sb3_pkg::ROW_W'(1));
         s1_in.frame_last = frame_end;
         s1_in.pixel      = req_chan.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // line memory holds {older row, newer row} per column
   sb3_line_ram #(
      .DATA_W (2*sb3_pkg::PIX_W),
      .DEPTH  (sb3_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (retire),
      .wr_addr (s1_ff.col),
      .wr_data ({rd_data[sb3_pkg::PIX_W-1:0], s1_ff.pixel}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   assign column.top = rd_data[2*sb3_pkg::PIX_W-1:sb3_pkg::PIX_W];
   assign column.mid = rd_data[sb3_pkg::PIX_W-1:0];
   assign column.bot = s1_ff.pixel;

   sb3_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift    (retire),
      .col_in   (column),
      .interior (s1_ff.interior),
      .grad_x   (win_gx),
      .grad_y   (win_gy)
   );

   // output register
   always_comb begin
      out_valid_in  = out_valid_ff;
      grad_x_in     = grad_x_ff;
      grad_y_in     = grad_y_ff;
      frame_last_in = frame_last_ff;
      if (advance) begin
         out_valid_in  = s1_valid_ff && s1_ff.emit;
         grad_x_in     = win_gx;
         grad_y_in     = win_gy;
         frame_last_in = s1_ff.frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grad_x_ff     <= grad_x_in;
      grad_y_ff     <= grad_y_in;
      frame_last_ff <= frame_last_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.grad_x     = grad_x_ff;
   assign rsp_chan.grad_y     = grad_y_ff;
   assign rsp_chan.frame_last = frame_last_ff;

   // checks
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && row_end) |=> (col_ff == '0))
      else $error("column count did not wrap at row end");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_end) |=> (col_ff == '0 && row_ff == '0))
      else $error("position did not wrap at frame end");

   a_ram_no_collide: assert property (@(posedge clock) disable iff (reset)
      (retire && accept) |-> (s1_ff.col != col_ff))
      else $error("line memory read and write hit the same column");

endmodule

`default_nettype wire

>>> sv/sb3_line_ram.sv
// sb3_line_ram: simple dual-port line memory, one write and one registered read per cycle
// no dependencies
`default_nettype none

module sb3_line_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/sb3_window.sv
// sb3_window: two stored window columns plus the incoming column, sobel x/y kernels
// depends on sb3_pkg
`default_nettype none

module sb3_window (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                shift,
   input  wire sb3_pkg::column_type                 col_in,
   input  wire logic                                interior,
   output logic signed [sb3_pkg::GRAD_W-1:0]        grad_x,
   output logic signed [sb3_pkg::GRAD_W-1:0]        grad_y
);

   sb3_pkg::column_type left_ff, left_in;
   sb3_pkg::column_type centre_ff, centre_in;

   logic [sb3_pkg::SUM_W-1:0] right_sum, left_sum, bot_sum, top_sum;

   always_comb begin
      left_in   = left_ff;
      centre_in = centre_ff;
      if (shift) begin
         left_in   = centre_ff;
         centre_in = col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         centre_ff <= '0;
      end else begin
         left_ff   <= left_in;
         centre_ff <= centre_in;
      end
   end

   // 1-2-1 weighted sums
   always_comb begin
      right_sum = sb3_pkg::SUM_W'(col_in.top) + (sb3_pkg::SUM_W'(col_in.mid) << 1)
                  + sb3_pkg::SUM_W'(col_in.bot);
      left_sum  = sb3_pkg::SUM_W'(left_ff.top) + (sb3_pkg::SUM_W'(left_ff.mid) << 1)
                  + sb3_pkg::SUM_W'(left_ff.bot);
      bot_sum   = sb3_pkg::SUM_W'(left_ff.bot) + (sb3_pkg::SUM_W'(centre_ff.bot) << 1)
                  + sb3_pkg::SUM_W'(col_in.bot);
      top_sum   = sb3_pkg::SUM_W'(left_ff.top) + (sb3_pkg::SUM_W'(centre_ff.top) << 1)
                  + sb3_pkg::SUM_W'(col_in.top);
   end

   always_comb begin
      grad_x = '0;
      grad_y = '0;
      if (interior) begin
         grad_x = $signed(right_sum - left_sum);
         grad_y = $signed(bot_sum - top_sum);
      end
   end

endmodule

`default_nettype wire
